// ===== rtl/lru_set_associative_cache_sim_unit_defines.svh =====
// Assertion macros for the LRU cache tag store unit.
// Taken in by the checker module; depends on nothing else.
`ifndef LRU_SET_ASSOCIATIVE_CACHE_SIM_UNIT_DEFINES_SVH
`define LRU_SET_ASSOCIATIVE_CACHE_SIM_UNIT_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define LSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define LSC_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lsc_pkg.sv =====
// Shared constants and types of the LRU cache tag store unit.
// No dependencies; every other file but the assertion macro header imports it.
package lsc_pkg;

    localparam int MAX_SET_BITS_DEF = 8;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int TAG_W            = 31;
    localparam int ADDR_W           = 32;
    localparam int CNT_W            = 32;
    localparam int CFG_DATA_W       = 5;
    localparam int CFG_IDX_W        = 2;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] CMD_MODIFY = 2'd2;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAY_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Geometry in use, already clamped into range.
    typedef struct packed {
        logic [3:0] set_bits;
        logic [3:0] way_count;
        logic [4:0] block_bits;
    } t_cfg;

endpackage

// ===== rtl/lsc_req_if.sv =====
// Request channel: one access item (command and byte address).
// Depends on lsc_pkg.
interface lsc_req_if;
    import lsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output command, output address, input ready);
    modport sink   (input valid, input command, input address, output ready);
endinterface

// ===== rtl/lsc_rsp_if.sv =====
// Result channel: outcome of one access and the running counts.
// Depends on lsc_pkg.
interface lsc_rsp_if;
    import lsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       outcome;
    logic             last;
    logic [CNT_W-1:0] hits_total;
    logic [CNT_W-1:0] misses_total;
    logic [CNT_W-1:0] evictions_total;

    modport source (output valid, output outcome, output last, output hits_total,
                    output misses_total, output evictions_total, input ready);
    modport sink   (input valid, input outcome, input last, input hits_total,
                    input misses_total, input evictions_total, output ready);
endinterface

// ===== rtl/lru_set_associative_cache_sim_unit.sv =====
// Set-associative cache tag store with LRU replacement, top level.
// Holds the geometry registers and wires the front end, the job queue and
// the back end. Depends on lsc_pkg, lsc_req_if, lsc_rsp_if and the submodules.
//
// Usage: write set_bits, way_count and block_bits through the write port
// (index 0, 1, 2) while the unit is idle; out-of-range values are clamped.
// Items enter on i_req (command, address) with valid/ready and are taken
// while the two-entry job queue has room. Each access yields one item on
// o_rsp; a modify yields two, the second always a hit, with last set on
// the final one. Counts of hits, misses and evictions ride with every item.
// The back end reads the set row as it pops an item, then ranks and writes
// back the tags through the single-port set memory, registering the result;
// it takes no new item until it is through with the last. A modify does a
// second rank and write-back step that reuses the updated row.
// When o_rsp stalls, the result holds in the output register, the back end
// waits and the queue fills, after which i_req.ready drops.
// Reset clears counters, queue and per-set valid flags at once (no clearing
// pass) and sets all three geometry registers to 1.
module lru_set_associative_cache_sim_unit #(
    parameter int MAX_SET_BITS = lsc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = lsc_pkg::MAX_WAYS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lsc_req_if.sink                          i_req,
    lsc_rsp_if.source                        o_rsp
);
    import lsc_pkg::*;

    localparam int JOB_W = MAX_SET_BITS + TAG_W + 1;

    logic [3:0]       r_set_bits;
    logic [3:0]       r_way_count;
    logic [4:0]       r_block_bits;
    t_cfg             w_cfg;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    logic [JOB_W-1:0] w_job;
    logic [JOB_W-1:0] w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 4'd1;
            r_way_count  <= 4'd1;
            r_block_bits <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SET_BITS:   r_set_bits   <= i_cfg_data[3:0];
                REG_WAY_COUNT:  r_way_count  <= i_cfg_data[3:0];
                REG_BLOCK_BITS: r_block_bits <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // clamp: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (r_set_bits == '0)                w_cfg.set_bits = 4'd1;
        else if (r_set_bits > MAX_SET_BITS)  w_cfg.set_bits = 4'(MAX_SET_BITS);
        else                                 w_cfg.set_bits = r_set_bits;
        if (r_way_count == '0)               w_cfg.way_count = 4'd1;
        else if (r_way_count > MAX_WAYS)     w_cfg.way_count = 4'(MAX_WAYS);
        else                                 w_cfg.way_count = r_way_count;
        if (r_block_bits == '0)              w_cfg.block_bits = 5'd1;
        else if (r_block_bits > 5'd16)       w_cfg.block_bits = 5'd16;
        else                                 w_cfg.block_bits = r_block_bits;
    end

    lsc_front #(
        .MAX_SET_BITS (MAX_SET_BITS)
    ) u_front (
        .i_req    (i_req),
        .i_cfg    (w_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    lsc_queue #(
        .W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lsc_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_empty (w_empty),
        .i_q_head  (w_head),
        .o_pop     (w_pop),
        .o_rsp     (o_rsp)
    );

endmodule

// ===== rtl/lsc_front.sv =====
// Front end: accepts request items and splits the address into set and tag.
// Depends on lsc_pkg and lsc_req_if.
module lsc_front #(
    parameter int MAX_SET_BITS = lsc_pkg::MAX_SET_BITS_DEF
) (
    lsc_req_if.sink                         i_req,
    input  lsc_pkg::t_cfg                   i_cfg,
    input  logic                            i_q_full,
    output logic                            o_push,
    output logic [MAX_SET_BITS+lsc_pkg::TAG_W:0] o_job
);
    import lsc_pkg::*;

    logic [ADDR_W-1:0]       w_set_sh;
    logic [ADDR_W-1:0]       w_tag_full;
    logic [5:0]              w_tag_amt;
    logic [MAX_SET_BITS-1:0] w_set_mask;
    logic [MAX_SET_BITS-1:0] w_set;
    logic [TAG_W-1:0]        w_tag;
    logic                    w_modify;

    always_comb begin
        w_set_sh   = i_req.address >> i_cfg.block_bits;
        w_set_mask = ~({MAX_SET_BITS{1'b1}} << i_cfg.set_bits);
        w_set      = w_set_sh[MAX_SET_BITS-1:0] & w_set_mask;
        w_tag_amt  = {1'b0, i_cfg.block_bits} + {2'b00, i_cfg.set_bits};
        w_tag_full = i_req.address >> w_tag_amt;
        w_tag      = w_tag_full[TAG_W-1:0];
        // an unknown command acts as a plain load
        w_modify   = (i_req.command == CMD_MODIFY);
    end

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;
    assign o_job       = {w_modify, w_tag, w_set};

endmodule

// ===== rtl/lsc_queue.sv =====
// Short FIFO of classified accesses between front and back end.
// Depends on lsc_pkg.
module lsc_queue #(
    parameter int W = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_head,
    output logic         o_full,
    output logic         o_empty
);
    import lsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W_Q-1:0] r_cnt;
    logic [PTR_W-1:0]   n_wp;
    logic [PTR_W-1:0]   n_rp;

    assign o_full  = (r_cnt == CNT_W_Q'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign n_wp    = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
    assign n_rp    = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W_Q'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W_Q'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/lsc_back.sv =====
// Back end: reads the set row, resolves hit or miss with LRU ranks,
// writes the row back and delivers results. Depends on lsc_pkg, lsc_rsp_if.
module lsc_back #(
    parameter int MAX_SET_BITS = lsc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = lsc_pkg::MAX_WAYS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lsc_pkg::t_cfg                        i_cfg,
    input  logic                                 i_q_empty,
    input  logic [MAX_SET_BITS+lsc_pkg::TAG_W:0] i_q_head,
    output logic                                 o_pop,
    lsc_rsp_if.source                            o_rsp
);
    import lsc_pkg::*;

    localparam int SETS   = 1 << MAX_SET_BITS;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RNK_W  = WAY_W;
    localparam int HELD_W = $clog2(MAX_WAYS + 1);

    typedef enum logic {S_IDLE, S_EX} t_state;

    // set rows: tags, line valid bits, recency ranks (0 = most recent)
    logic [MAX_WAYS-1:0][TAG_W-1:0] r_tag_mem [SETS];
    logic [MAX_WAYS-1:0]            r_vld_mem [SETS];
    logic [MAX_WAYS-1:0][RNK_W-1:0] r_rnk_mem [SETS];
    logic [SETS-1:0]                r_row_ok;

    t_state                         r_state;
    logic [MAX_SET_BITS-1:0]        r_set;
    logic [TAG_W-1:0]               r_tag;
    logic                           r_modify;
    logic                           r_second;
    logic                           r_rd_ok;
    logic [MAX_WAYS-1:0][TAG_W-1:0] r_rd_tag;
    logic [MAX_WAYS-1:0]            r_rd_vld;
    logic [MAX_WAYS-1:0][RNK_W-1:0] r_rd_rnk;
    logic                           r_out_vld;
    logic [1:0]                     r_outcome;
    logic                           r_last;
    logic [CNT_W-1:0]               r_hits;
    logic [CNT_W-1:0]               r_misses;
    logic [CNT_W-1:0]               r_evicts;

    logic [MAX_WAYS-1:0][TAG_W-1:0] n_tag;
    logic [MAX_WAYS-1:0]            n_vld;
    logic [MAX_WAYS-1:0][RNK_W-1:0] n_rnk;
    logic [1:0]                     n_outcome;

    logic [MAX_SET_BITS-1:0]        w_head_set;
    logic [MAX_WAYS-1:0]            w_vld;
    logic [MAX_WAYS-1:0][RNK_W-1:0] w_rnk;
    logic                           w_hit;
    logic [WAY_W-1:0]               w_hit_way;
    logic [RNK_W-1:0]               w_hit_rank;
    logic [HELD_W-1:0]              w_held;
    logic [WAY_W-1:0]               w_victim;
    logic                           w_have_victim;
    logic [RNK_W-1:0]               w_oldest;
    logic [WAY_W-1:0]               w_slot;
    logic                           w_have_free;
    logic                           w_evict;
    logic                           w_go;
    logic                           w_again;

    assign w_head_set = i_q_head[MAX_SET_BITS-1:0];
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;
    assign w_go       = (r_state == S_EX) && (!r_out_vld || o_rsp.ready);
    assign w_again    = r_modify && !r_second;

    // a row never written reads as all lines invalid, ranks zero
    assign w_vld = r_rd_ok ? r_rd_vld : '0;
    assign w_rnk = r_rd_ok ? r_rd_rnk : '0;

    always_comb begin
        w_hit         = 1'b0;
        w_hit_way     = '0;
        w_held        = '0;
        w_victim      = '0;
        w_have_victim = 1'b0;
        w_oldest      = '0;
        w_slot        = '0;
        w_have_free   = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (w_vld[w] && (r_rd_tag[w] == r_tag) && !w_hit) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_W'(w);
            end
            if (w_vld[w]) begin
                w_held = w_held + HELD_W'(1);
                // highest rank wins, later way on a tie
                if (!w_have_victim || (w_rnk[w] >= w_oldest)) begin
                    w_victim      = WAY_W'(w);
                    w_oldest      = w_rnk[w];
                    w_have_victim = 1'b1;
                end
            end else if (!w_have_free) begin
                w_have_free = 1'b1;
                w_slot      = WAY_W'(w);
            end
        end
        w_hit_rank = w_rnk[w_hit_way];
        w_evict    = (5'(w_held) >= 5'(i_cfg.way_count));

        n_tag = r_rd_tag;
        n_vld = w_vld;
        n_rnk = w_rnk;
        if (w_hit) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (w_vld[w] && (w_rnk[w] < w_hit_rank)) begin
                    n_rnk[w] = w_rnk[w] + RNK_W'(1);
                end
            end
            n_rnk[w_hit_way] = '0;
            n_outcome        = OUT_HIT;
        end else if (w_evict) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (w_vld[w] && (WAY_W'(w) != w_victim)) begin
                    n_rnk[w] = w_rnk[w] + RNK_W'(1);
                end
            end
            n_tag[w_victim] = r_tag;
            n_rnk[w_victim] = '0;
            n_outcome       = OUT_EVICT;
        end else begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (w_vld[w]) begin
                    n_rnk[w] = w_rnk[w] + RNK_W'(1);
                end
            end
            n_tag[w_slot] = r_tag;
            n_vld[w_slot] = 1'b1;
            n_rnk[w_slot] = '0;
            n_outcome     = OUT_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_second  <= 1'b0;
            r_rd_ok   <= 1'b0;
            r_row_ok  <= '0;
            r_out_vld <= 1'b0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
        end else begin
            // load a new result, or drop the one the receiver took
            if (w_go) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_set    <= w_head_set;
                        r_tag    <= i_q_head[MAX_SET_BITS +: TAG_W];
                        r_modify <= i_q_head[MAX_SET_BITS+TAG_W];
                        r_second <= 1'b0;
                        r_rd_ok  <= r_row_ok[w_head_set];
                        r_state  <= S_EX;
                    end
                end
                S_EX: begin
                    if (w_go) begin
                        r_row_ok[r_set] <= 1'b1;
                        r_outcome       <= n_outcome;
                        r_last          <= !w_again;
                        if (w_hit) begin
                            if (r_hits != CNT_MAX) r_hits <= r_hits + CNT_W'(1);
                        end else begin
                            if (r_misses != CNT_MAX) r_misses <= r_misses + CNT_W'(1);
                            if (w_evict && (r_evicts != CNT_MAX)) begin
                                r_evicts <= r_evicts + CNT_W'(1);
                            end
                        end
                        // second access of a modify reuses the updated row
                        if (w_again) begin
                            r_second <= 1'b1;
                            r_rd_ok  <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_tag_mem[r_set] <= n_tag;
            r_vld_mem[r_set] <= n_vld;
            r_rnk_mem[r_set] <= n_rnk;
        end
        if (o_pop) begin
            r_rd_tag <= r_tag_mem[w_head_set];
            r_rd_vld <= r_vld_mem[w_head_set];
            r_rd_rnk <= r_rnk_mem[w_head_set];
        end else if (w_go) begin
            r_rd_tag <= n_tag;
            r_rd_vld <= n_vld;
            r_rd_rnk <= n_rnk;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.outcome         = r_outcome;
    assign o_rsp.last            = r_last;
    assign o_rsp.hits_total      = r_hits;
    assign o_rsp.misses_total    = r_misses;
    assign o_rsp.evictions_total = r_evicts;

endmodule

// ===== rtl/lsc_checker.sv =====
// Port-level checks on the result channel of the LRU cache unit, with the
// bind that attaches them. Depends on lsc_pkg and the assertion macro header.
`include "lru_set_associative_cache_sim_unit_defines.svh"

module lsc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                i_outcome,
    input logic                      i_last,
    input logic [lsc_pkg::CNT_W-1:0] i_hits,
    input logic [lsc_pkg::CNT_W-1:0] i_misses,
    input logic [lsc_pkg::CNT_W-1:0] i_evicts
);
    import lsc_pkg::*;

    // set after a result that is not the last of its item
    logic r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_pend <= !i_last;
        end
    end

    `LSC_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_outcome) && $stable(i_hits) && $stable(i_last), "stalled result changed")
    `LSC_ASSERT_NORST(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `LSC_ASSERT(a_modify_hit, i_clk, i_rst_n, r_pend && i_out_valid |-> (i_outcome == OUT_HIT) && i_last, "second access of modify did not hit")
    `LSC_ASSERT(a_evict_le_miss, i_clk, i_rst_n, i_out_valid |-> (i_evicts <= i_misses), "evictions exceed misses")

endmodule

bind lru_set_associative_cache_sim_unit lsc_checker u_lsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_outcome   (o_rsp.outcome),
    .i_last      (o_rsp.last),
    .i_hits      (o_rsp.hits_total),
    .i_misses    (o_rsp.misses_total),
    .i_evicts    (o_rsp.evictions_total)
);

// ===== verif/lru_set_associative_cache_sim_unit_tb.sv =====
// Self-checking testbench for the LRU set-associative cache tag store unit.
// Predicts hit, miss and eviction per access plus the running counts, and
// depends on lsc_pkg, lsc_req_if, lsc_rsp_if and the unit's RTL.
module lru_set_associative_cache_sim_unit_tb;
    import lsc_pkg::*;

    localparam int LINE_COUNT      = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RUN_LIMIT       = 1_000_000;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_STORE   = 2'd1;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [1:0]       outcome;
        logic             last;
        logic [CNT_W-1:0] hits_total;
        logic [CNT_W-1:0] misses_total;
        logic [CNT_W-1:0] evictions_total;
    } cache_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lsc_req_if req ();
    lsc_rsp_if rsp ();

    lru_set_associative_cache_sim_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .o_rsp      (rsp)
    );

    always #2 i_clk = ~i_clk;

    // Tag store mirror and running counts
    logic [TAG_W-1:0] line_tag  [LINE_COUNT];
    bit               line_held [LINE_COUNT];
    int unsigned      line_age  [LINE_COUNT];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] evict_count;
    logic [3:0]       cfg_set_bits;
    logic [3:0]       cfg_way_count;
    logic [4:0]       cfg_block_bits;

    cache_result_t expected_results [$];
    int unsigned   error_count = 0;
    bit            idling_on = 1'b1;
    bit            hold_off_pending = 1'b0;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] bump_count(logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic void reset_model();
        foreach (line_held[i]) begin
            line_held[i] = 1'b0;
            line_age[i]  = 0;
        end
        hit_count      = '0;
        miss_count     = '0;
        evict_count    = '0;
        cfg_set_bits   = 4'd1;
        cfg_way_count  = 4'd1;
        cfg_block_bits = 5'd1;
    endfunction

    // Look up one address and update the mirror; returns the outcome code.
    function automatic logic [1:0] touch_line(input logic [ADDR_W-1:0] addr);
        int unsigned s, e, b, base, held, slot, victim, oldest, rank;
        logic [63:0] wide;
        logic [TAG_W-1:0] tag;
        bit found_free;
        s = clamp_to(cfg_set_bits, 1, MAX_SET_BITS_DEF);
        e = clamp_to(cfg_way_count, 1, MAX_WAYS_DEF);
        b = clamp_to(cfg_block_bits, 1, 16);
        wide = {32'd0, addr};
        base = 32'(((wide >> b) & ((64'd1 << s) - 1)) * MAX_WAYS_DEF);
        tag = TAG_W'(wide >> (b + s));
        held = 0;
        slot = MAX_WAYS_DEF;
        victim = MAX_WAYS_DEF;
        oldest = 0;
        found_free = 1'b0;

        for (int w = 0; w < MAX_WAYS_DEF; w++) begin
            if (line_held[base + w] && line_tag[base + w] == tag) begin
                rank = line_age[base + w];
                for (int k = 0; k < MAX_WAYS_DEF; k++) begin
                    if (line_held[base + k] && line_age[base + k] < rank)
                        line_age[base + k]++;
                end
                line_age[base + w] = 0;
                hit_count = bump_count(hit_count);
                return OUT_HIT;
            end
        end

        // Pick the oldest held line (last one on a tie) and the first free way
        for (int w = 0; w < MAX_WAYS_DEF; w++) begin
            if (line_held[base + w]) begin
                held++;
                if (victim == MAX_WAYS_DEF || line_age[base + w] >= oldest) begin
                    victim = w;
                    oldest = line_age[base + w];
                end
            end else if (!found_free) begin
                found_free = 1'b1;
                slot = w;
            end
        end

        miss_count = bump_count(miss_count);
        if (held >= e) begin
            for (int w = 0; w < MAX_WAYS_DEF; w++) begin
                if (line_held[base + w] && w != victim)
                    line_age[base + w]++;
            end
            line_tag[base + victim] = tag;
            line_age[base + victim] = 0;
            evict_count = bump_count(evict_count);
            return OUT_EVICT;
        end
        for (int w = 0; w < MAX_WAYS_DEF; w++) begin
            if (line_held[base + w])
                line_age[base + w]++;
        end
        line_tag[base + slot]  = tag;
        line_held[base + slot] = 1'b1;
        line_age[base + slot]  = 0;
        return OUT_MISS;
    endfunction

    function automatic void record_access(logic [1:0] cmd, logic [ADDR_W-1:0] addr);
        logic [1:0] r;
        r = touch_line(addr);
        if (cmd == CMD_MODIFY) begin
            expected_results.push_back('{r, 1'b0, hit_count, miss_count, evict_count});
            r = touch_line(addr);
        end
        expected_results.push_back('{r, 1'b1, hit_count, miss_count, evict_count});
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        cache_result_t want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
                $error("result item arrived with nothing expected");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("outcome", want.outcome, rsp.outcome);
                check_field("last", want.last, rsp.last);
                check_field("hits_total", want.hits_total, rsp.hits_total);
                check_field("misses_total", want.misses_total, rsp.misses_total);
                check_field("evictions_total", want.evictions_total, rsp.evictions_total);
            end
        end
    end

    // Result side pacing: random short stalls, plus one long hold on request
    initial begin : result_pacer
        int unsigned idle_left;
        idle_left = 0;
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                idle_left = HOLD_OFF_CYCLES;
            end else if (idle_left == 0 && idling_on && $urandom_range(0, 4) == 0) begin
                idle_left = $urandom_range(1, 3);
            end
            if (idle_left != 0) begin
                rsp.ready <= 1'b0;
                idle_left--;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic send_access(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid   <= 1'b1;
        req.command <= cmd;
        req.address <= addr;
        do @(posedge i_clk); while (!req.ready);
        record_access(cmd, addr);
    endtask

    // Drop valid and wait until every expected item is back
    task automatic settle_unit();
        req.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [4:0] s, input logic [4:0] w, input logic [4:0] b);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SET_BITS;
        i_cfg_data <= s;
        @(posedge i_clk);
        cfg_set_bits = s[3:0];
        i_cfg_idx  <= REG_WAY_COUNT;
        i_cfg_data <= w;
        @(posedge i_clk);
        cfg_way_count = w[3:0];
        i_cfg_idx  <= REG_BLOCK_BITS;
        i_cfg_data <= b;
        @(posedge i_clk);
        cfg_block_bits = b;
        i_cfg_we <= 1'b0;
    endtask

    // Mostly addresses from a small pool of tags and sets so that hits and
    // evictions both happen; one in eight is a fully random address.
    task automatic send_random_access(input int unsigned tag_base, input int unsigned tag_span,
                                      input int unsigned set_span);
        int unsigned pick, s, b;
        logic [1:0] cmd;
        logic [63:0] tag_part, set_part, offset_part;
        pick = $urandom_range(0, 15);
        if (pick == 0) cmd = CMD_UNKNOWN;
        else if (pick <= 5) cmd = CMD_LOAD;
        else if (pick <= 10) cmd = CMD_STORE;
        else cmd = CMD_MODIFY;
        s = clamp_to(cfg_set_bits, 1, MAX_SET_BITS_DEF);
        b = clamp_to(cfg_block_bits, 1, 16);
        if ($urandom_range(0, 7) == 0) begin
            send_access(cmd, $urandom);
        end else begin
            tag_part    = 64'(32'(tag_base + $urandom_range(0, tag_span))) << (b + s);
            set_part    = (64'($urandom_range(0, set_span)) & ((64'd1 << s) - 1)) << b;
            offset_part = 64'($urandom) & ((64'd1 << b) - 1);
            send_access(cmd, ADDR_W'(tag_part | set_part | offset_part));
        end
    endtask

    task automatic run_random_phase(input logic [4:0] s, input logic [4:0] w,
                                    input logic [4:0] b, input int unsigned count,
                                    input bit hold_receiver);
        int unsigned tag_base, tag_span, set_span;
        settle_unit();
        set_geometry(s, w, b);
        tag_base = $urandom;
        tag_span = clamp_to(cfg_way_count, 1, MAX_WAYS_DEF) + $urandom_range(0, 3);
        set_span = $urandom_range(0, 3);
        if (hold_receiver) hold_off_pending = 1'b1;
        repeat (count) send_random_access(tag_base, tag_span, set_span);
    endtask

    // Geometry left at its reset value: one set bit, one way, one offset bit
    task automatic test_reset_geometry();
        send_access(CMD_LOAD, 32'h0000_0000);
        send_access(CMD_LOAD, 32'h0000_0001);
        send_access(CMD_STORE, 32'h0000_0002);
        send_access(CMD_MODIFY, 32'h0000_0004);
        send_access(CMD_LOAD, 32'h0000_0000);
        send_access(CMD_UNKNOWN, 32'h0000_0001);
        send_access(CMD_LOAD, 32'hFFFF_FFFF);
        send_access(CMD_STORE, 32'hFFFF_FFFE);
        send_access(CMD_MODIFY, 32'h7FFF_FFFD);
    endtask

    // Fill a four-way set, then check which line gets replaced
    task automatic test_lru_order();
        settle_unit();
        set_geometry(5'd2, 5'd4, 5'd4);
        for (int t = 0; t < 4; t++) send_access(CMD_LOAD, ADDR_W'(t << 6));
        send_access(CMD_LOAD, 32'h0000_0000);
        send_access(CMD_STORE, 32'h0000_0100);
        send_access(CMD_LOAD, 32'h0000_0040);
        send_access(CMD_MODIFY, 32'h0000_0080);
    endtask

    // Set holds more lines than the new associativity
    task automatic test_way_count_lowered();
        settle_unit();
        set_geometry(5'd2, 5'd2, 5'd4);
        send_access(CMD_LOAD, 32'h0000_0240);
        send_access(CMD_LOAD, 32'h0000_0100);
        send_access(CMD_STORE, 32'h0000_00C0);
    endtask

    // Lines stay valid and are looked up under the new geometry
    task automatic test_geometry_change();
        settle_unit();
        set_geometry(5'd3, 5'd2, 5'd3);
        send_access(CMD_LOAD, 32'h0000_0000);
        send_access(CMD_LOAD, 32'h0000_0080);
        send_access(CMD_MODIFY, 32'h0000_01C0);
    endtask

    // Zero and over-range register values saturate into range
    task automatic test_register_clamp();
        settle_unit();
        set_geometry(5'd0, 5'd0, 5'd0);
        send_access(CMD_LOAD, 32'h0000_0000);
        send_access(CMD_MODIFY, 32'h0000_0003);
        settle_unit();
        set_geometry(5'd31, 5'd15, 5'd31);
        send_access(CMD_LOAD, 32'hFFFF_0000);
        send_access(CMD_LOAD, 32'h0001_FFFF);
    endtask

    task automatic test_random_geometry();
        run_random_phase(5'd1, 5'd1, 5'd1, 140, 1'b0);
        run_random_phase(5'd8, 5'd8, 5'd16, 140, 1'b0);
        run_random_phase(5'd0, 5'd0, 5'd0, 140, 1'b0);
        run_random_phase(5'd15, 5'd15, 5'd31, 140, 1'b0);
        repeat (2) begin
            run_random_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                             5'($urandom_range(0, 31)), 140, 1'b0);
        end
    endtask

    // Receiver holds off long enough for the job queue to fill
    task automatic test_back_pressure();
        run_random_phase(5'd4, 5'd2, 5'd3, 40, 1'b1);
    endtask

    task automatic test_steady_stream();
        idling_on = 1'b0;
        run_random_phase(5'd3, 5'd8, 5'd6, 300, 1'b0);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= REG_SET_BITS;
        i_cfg_data  <= '0;
        req.valid   <= 1'b0;
        req.command <= CMD_LOAD;
        req.address <= '0;
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_lru_order();
        test_way_count_lowered();
        test_geometry_change();
        test_register_clamp();
        test_random_geometry();
        test_back_pressure();
        test_steady_stream();
        settle_unit();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lsc_pkg.sv
rtl/lsc_req_if.sv
rtl/lsc_rsp_if.sv
rtl/lsc_front.sv
rtl/lsc_queue.sv
rtl/lsc_back.sv
rtl/lru_set_associative_cache_sim_unit.sv
rtl/lsc_checker.sv
verif/lru_set_associative_cache_sim_unit_tb.sv
